// ===== hw/rtl/dpom_pkg.sv =====
// ----------------------------------------------------------------------------
// dpom_pkg: shared constants and types of the dust pulse occupancy meter
// Counter widths, fixed-point coefficients, register indexes and the
// structs that pass between the tick counter, MAC and sequencer.
// ----------------------------------------------------------------------------
package dpom_pkg;

	// time base and counters
	localparam int TICKS_PER_MS = 1000;
	localparam int PRESCALE_W   = $clog2(TICKS_PER_MS + 1);
	localparam int CNT_W        = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int MS_W         = 16;

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_MS = 4'd1;
	localparam logic [MS_W-1:0] WINDOW_MS_RST = 16'd30000;
	localparam logic [MS_W-1:0] WARMUP_MS_RST = 16'd30000;

	// divider: (total << 16) / (window_ms * 10)
	localparam int DIVD_W    = CNT_W + 16;
	localparam int DIVS_W    = 20;
	localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
	localparam int RATIO_W   = 23;

	// serial multiply-accumulate
	localparam int ACC_W = 64;
	localparam int MB_W  = 26;
	localparam logic [MB_W-1:0] K_CUBE   = 26'd72090;
	localparam logic [MB_W-1:0] K_SQUARE = 26'd249037;
	localparam logic [MB_W-1:0] K_LINEAR = 26'd34078720;
	localparam logic [MB_W-1:0] K_X100   = 26'd100;
	localparam logic [ACC_W-1:0] ACC_CONST = 64'd40632 << 16;
	localparam logic [ACC_W-1:0] ACC_ROUND = 64'h0000_0000_8000_0000;

	// result
	localparam int CONC_W = 28;
	localparam logic [CONC_W-1:0] VALID_LOW  = 28'd63;
	localparam logic [CONC_W-1:0] VALID_HIGH = 28'd111400000;

	// window close event from the tick counter
	typedef struct packed {
		logic             close;
		logic             warmed;
		logic [CNT_W-1:0] total;
		logic [MS_W-1:0]  win;
	} tick_evt_t;

	// one multiply-accumulate command
	typedef struct packed {
		logic             start;
		logic             sub;
		logic [ACC_W-1:0] init;
		logic [ACC_W-1:0] a;
		logic [MB_W-1:0]  b;
	} mac_cmd_t;

endpackage

// ===== hw/rtl/dpom_tick.sv =====
// ----------------------------------------------------------------------------
// dpom_tick: pulse timing and millisecond counters
// Times low pulses, sums them per window, runs the millisecond prescaler,
// warm-up and window counters, and flags the item that closes a window.
// ----------------------------------------------------------------------------
module dpom_tick import dpom_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            pin_low,
	input  logic [MS_W-1:0] window_ms,
	input  logic [MS_W-1:0] warmup_ms,
	output tick_evt_t       evt
);

	logic                  level_q;
	logic [CNT_W-1:0]      pulse_q, pulse_d;
	logic [CNT_W-1:0]      total_q, total_d;
	logic [CNT_W:0]        sum;
	logic [PRESCALE_W-1:0] prescale_q, prescale_d;
	logic [MS_W-1:0]       wcnt_q, wcnt_d, wcnt_inc;
	logic [MS_W-1:0]       warm_cnt_q, warm_cnt_d;
	logic                  warmed_q, warmed_d;
	logic                  ms_tick;
	logic                  close;
	logic [MS_W-1:0]       win_eff;

	// next state for one sample
	always_comb begin
		pulse_d = pulse_q;
		total_d = total_q;
		sum = {1'b0, total_q} + {1'b0, pulse_q};
		if (pin_low) begin
			if (!level_q)
				pulse_d = CNT_W'(1);
			else if (pulse_q != CNT_MAX)
				pulse_d = pulse_q + CNT_W'(1);
		end else if (level_q) begin
			total_d = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
			pulse_d = '0;
		end

		ms_tick = (prescale_q == PRESCALE_W'(TICKS_PER_MS - 1));
		prescale_d = ms_tick ? '0 : prescale_q + PRESCALE_W'(1);

		// warm-up latches once and stays
		warmed_d = warmed_q;
		warm_cnt_d = warm_cnt_q;
		if (ms_tick && !warmed_q) begin
			if (warm_cnt_q >= warmup_ms)
				warmed_d = 1'b1;
			else
				warm_cnt_d = warm_cnt_q + MS_W'(1);
		end

		// window counter, zero length acts as one millisecond
		win_eff = (window_ms == '0) ? MS_W'(1) : window_ms;
		wcnt_inc = (wcnt_q != {MS_W{1'b1}}) ? wcnt_q + MS_W'(1) : wcnt_q;
		close = ms_tick && (wcnt_inc >= win_eff);
		if (!ms_tick)
			wcnt_d = wcnt_q;
		else if (close)
			wcnt_d = '0;
		else
			wcnt_d = wcnt_inc;
	end

	assign evt.close  = close;
	assign evt.warmed = warmed_d;
	assign evt.total  = total_d;
	assign evt.win    = win_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= 1'b0;
			pulse_q    <= '0;
			total_q    <= '0;
			prescale_q <= '0;
			wcnt_q     <= '0;
			warm_cnt_q <= '0;
			warmed_q   <= 1'b0;
		end else if (step) begin
			level_q    <= pin_low;
			pulse_q    <= pulse_d;
			total_q    <= close ? '0 : total_d;
			prescale_q <= prescale_d;
			wcnt_q     <= wcnt_d;
			warm_cnt_q <= warm_cnt_d;
			warmed_q   <= warmed_d;
		end
	end

endmodule

// ===== hw/rtl/dpom_div.sv =====
// ----------------------------------------------------------------------------
// dpom_div: bit-serial restoring divider
// One quotient bit per cycle; the dividend shift register turns into the
// quotient after DIVD_W steps.
// ----------------------------------------------------------------------------
module dpom_div import dpom_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              busy,
	output logic [DIVD_W-1:0] quo
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVS_W-1:0]    d_q;
	logic [DIVD_W-1:0]    n_q;
	logic [DIVS_W:0]      trial;
	logic [DIVS_W+1:0]    diff;
	logic                 ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, n_q[DIVD_W-1]};
		diff  = {1'b0, trial} - {2'b00, d_q};
		ge    = !diff[DIVS_W+1];
	end

	assign busy = (cnt_q != '0);
	assign quo  = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIVD_W);
		end else if (busy) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			d_q   <= divisor;
			n_q   <= dividend;
		end else if (busy) begin
			rem_q <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			n_q   <= {n_q[DIVD_W-2:0], ge};
		end
	end

endmodule

// ===== hw/rtl/dpom_mac.sv =====
// ----------------------------------------------------------------------------
// dpom_mac: serial shift-add multiply-accumulate
// Retires one multiplier bit per cycle: acc = init +/- a * b. Finishes as
// soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module dpom_mac import dpom_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mac_cmd_t         cmd,
	output logic             busy,
	output logic [ACC_W-1:0] acc
);

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] a_q;
	logic [MB_W-1:0]  b_q;
	logic             sub_q;

	assign busy = (b_q != '0);
	assign acc  = acc_q;

	// multiplier bits are control: they decide when the unit is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q   <= '0;
			sub_q <= 1'b0;
		end else if (cmd.start) begin
			b_q   <= cmd.b;
			sub_q <= cmd.sub;
		end else if (busy) begin
			b_q   <= b_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= cmd.init;
			a_q   <= cmd.a;
		end else if (busy) begin
			if (b_q[0])
				acc_q <= sub_q ? acc_q - a_q : acc_q + a_q;
			a_q <= a_q << 1;
		end
	end

endmodule

// ===== hw/rtl/dust_pulse_occupancy_meter_unit.sv =====
// ----------------------------------------------------------------------------
// dust_pulse_occupancy_meter_unit: dust sensor low pulse occupancy meter
// After the item that closes a window the result takes a 48-step serial divide,
// then six shift-add multiplies whose length follows the multiplier bits, and
// is loaded into the output register once the output is free.
// Throughput: one item per cycle; after a window-closing item s_tready stays
// low until its result sits in the output register.
// Reset: asynchronous, clears all counters and the output valid; both registers
// return to 30000 ms.
// ----------------------------------------------------------------------------
module dust_pulse_occupancy_meter_unit import dpom_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [0] pin_low
	// result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [87:0]          m_tdata,   // [27:0] reported_x100, [55:28] raw_x100,
	                                        // [87:56] low_time_us
	output logic [0:0]           m_tuser,   // [0] value_valid
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_RR   = 4'd2;
	localparam logic [3:0] S_R2R  = 4'd3;
	localparam logic [3:0] S_CUBE = 4'd4;
	localparam logic [3:0] S_SQ   = 4'd5;
	localparam logic [3:0] S_LIN  = 4'd6;
	localparam logic [3:0] S_X100 = 4'd7;

	logic [3:0]         state_q, state_d;
	logic [MS_W-1:0]    window_ms_q, warmup_ms_q;
	logic               step;
	tick_evt_t          evt;
	logic               div_start, div_busy;
	logic [DIVD_W-1:0]  quo;
	logic [DIVS_W-1:0]  divisor;
	mac_cmd_t           mac_cmd;
	logic               mac_busy;
	logic [ACC_W-1:0]   acc;
	logic [RATIO_W-1:0] r_sat, r_q;
	logic [29:0]        r2_q;
	logic               r_ld, r2_ld, out_ld, snap_ld;
	logic [CNT_W-1:0]   total_q;
	logic               warmed_q;
	logic [CONC_W-1:0]  raw;
	logic               valid;
	logic               out_valid_q;
	logic [CONC_W-1:0]  out_rep_q, out_raw_q;
	logic [CNT_W-1:0]   out_low_q;
	logic               out_valid_flag_q;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q <= WINDOW_MS_RST;
			warmup_ms_q <= WARMUP_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WINDOW_MS: window_ms_q <= cfg_data;
				REG_WARMUP_MS: warmup_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-sample counters
	assign s_tready = (state_q == S_IDLE);
	assign step     = s_tvalid && s_tready;

	dpom_tick u_tick (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.pin_low   (s_tdata[0]),
		.window_ms (window_ms_q),
		.warmup_ms (warmup_ms_q),
		.evt       (evt)
	);

	// ratio divide: window_ms * 10 as two shifts
	assign divisor = (DIVS_W'(evt.win) << 3) + (DIVS_W'(evt.win) << 1);

	dpom_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({evt.total, 16'h0000}),
		.divisor  (divisor),
		.busy     (div_busy),
		.quo      (quo)
	);

	dpom_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.busy   (mac_busy),
		.acc    (acc)
	);

	// ratio saturates at 127.99998 in Q7.16
	assign r_sat = (quo[DIVD_W-1:RATIO_W] != '0) ? {RATIO_W{1'b1}} : quo[RATIO_W-1:0];

	assign raw   = acc[32 +: CONC_W];
	assign valid = warmed_q && (raw > VALID_LOW) && (raw < VALID_HIGH);

	// sequencer: divide, r^2, r^3, cubic accumulate, scale by 100
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		mac_cmd   = '0;
		r_ld      = 1'b0;
		r2_ld     = 1'b0;
		out_ld    = 1'b0;
		snap_ld   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (step && evt.close) begin
					div_start = 1'b1;
					snap_ld   = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (!div_busy) begin
					r_ld          = 1'b1;
					mac_cmd.start = 1'b1;
					mac_cmd.a     = ACC_W'(r_sat);
					mac_cmd.b     = MB_W'(r_sat);
					state_d       = S_RR;
				end
			end
			S_RR: begin
				if (!mac_busy) begin
					r2_ld         = 1'b1;
					mac_cmd.start = 1'b1;
					mac_cmd.a     = ACC_W'(acc[45:16]);
					mac_cmd.b     = MB_W'(r_q);
					state_d       = S_R2R;
				end
			end
			S_R2R: begin
				if (!mac_busy) begin
					mac_cmd.start = 1'b1;
					mac_cmd.init  = ACC_CONST;
					mac_cmd.a     = ACC_W'(acc[52:16]);
					mac_cmd.b     = K_CUBE;
					state_d       = S_CUBE;
				end
			end
			S_CUBE: begin
				if (!mac_busy) begin
					mac_cmd.start = 1'b1;
					mac_cmd.sub   = 1'b1;
					mac_cmd.init  = acc;
					mac_cmd.a     = ACC_W'(r2_q);
					mac_cmd.b     = K_SQUARE;
					state_d       = S_SQ;
				end
			end
			S_SQ: begin
				if (!mac_busy) begin
					mac_cmd.start = 1'b1;
					mac_cmd.init  = acc;
					mac_cmd.a     = ACC_W'(r_q);
					mac_cmd.b     = K_LINEAR;
					state_d       = S_LIN;
				end
			end
			S_LIN: begin
				// negative sum clamps to zero, then round half up
				if (!mac_busy) begin
					mac_cmd.start = 1'b1;
					mac_cmd.init  = ACC_ROUND;
					mac_cmd.a     = acc[ACC_W-1] ? '0 : acc;
					mac_cmd.b     = K_X100;
					state_d       = S_X100;
				end
			end
			S_X100: begin
				if (!mac_busy && (!out_valid_q || m_tready)) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		if (snap_ld) begin
			total_q  <= evt.total;
			warmed_q <= evt.warmed;
		end
		if (r_ld)
			r_q <= r_sat;
		if (r2_ld)
			r2_q <= acc[45:16];
		if (out_ld) begin
			out_rep_q        <= valid ? raw : '0;
			out_raw_q        <= raw;
			out_low_q        <= total_q;
			out_valid_flag_q <= valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_low_q, out_raw_q, out_rep_q};
	assign m_tuser  = out_valid_flag_q;

endmodule
